// ===== rtl/twrm_pkg.sv =====
`timescale 1ns / 1ps
// twrm_pkg: shared types and constants of the triple window rate meter.
// No dependencies; every other file of the meter imports it.

package twrm_pkg;

    // Fixed field widths
    localparam int BYTE_BITS = 32;
    localparam int NOW_BITS  = 40;
    localparam int LEN_BITS  = 32;
    localparam int RATE_BITS = 48;
    localparam int ZERO_BITS = 3;

    // Defaults of the top level parameters
    localparam int TIME_BITS_DEF   = 40;
    localparam int SUM_BITS_DEF    = 48;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Scale from ms to s, and width added to the sum by that scale
    localparam int MS_PER_S   = 1000;
    localparam int SCALE_BITS = 10;

    // Windows
    localparam int       NUM_WIN  = 3;
    localparam logic [1:0] WIN_SHORT = 2'd0;
    localparam logic [1:0] WIN_MID   = 2'd1;
    localparam logic [1:0] WIN_LONG  = 2'd2;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_WIN_SHORT = 2'd0;
    localparam logic [1:0] CFG_WIN_MID   = 2'd1;
    localparam logic [1:0] CFG_WIN_LONG  = 2'd2;

    // Register reset values
    localparam logic [LEN_BITS-1:0] WIN_SHORT_RST = 32'd2000;
    localparam logic [LEN_BITS-1:0] WIN_MID_RST   = 32'd10000;
    localparam logic [LEN_BITS-1:0] WIN_LONG_RST  = 32'd30000;

    localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

    // Input word: one transfer event
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_count;
        logic [NOW_BITS-1:0]  now_ms;
    } twrm_in_t;

    // Output word: rates of all three windows
    typedef struct packed {
        logic [RATE_BITS-1:0] rate_short;
        logic [RATE_BITS-1:0] rate_mid;
        logic [RATE_BITS-1:0] rate_long;
        logic [ZERO_BITS-1:0] zero_elapsed;
    } twrm_out_t;

    // Window lengths as handed to the back end
    typedef logic [NUM_WIN-1:0][LEN_BITS-1:0] twrm_len_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } twrm_div_stat_t;

endpackage

// ===== rtl/triple_window_rate_meter_top.sv =====
`timescale 1ns / 1ps
// triple_window_rate_meter_top: top level of the three window rate meter.
// Holds the window length registers; uses twrm_pkg, twrm_queue, twrm_core.
//
//  channel  direction  handshake               word
//  s_*      in         s_valid / s_ready       twrm_in_t  (byte_count, now_ms)
//  m_*      out        m_valid / m_ready       twrm_out_t (three rates, zero flags)
//  cfg_*    in         cfg_wr_en, no wait      cfg_addr selects a window length
//
//  Each window runs through the shared restoring divider (one quotient bit per
//  cycle, SUM_BITS + 10 bits per window); a window with zero elapsed time
//  skips it. The input queue takes words, until it is full, while the back
//  end works or while a result word waits on m_ready. Reset is synchronous,
//  active low, and needs no clearing pass.

module triple_window_rate_meter_top
    import twrm_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  twrm_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output twrm_out_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [LEN_BITS-1:0] cfg_wdata
);

    twrm_len_t win_len_reg;
    logic      q_valid;
    twrm_in_t  q_data;
    logic      q_pop;

    // window length registers; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg[WIN_SHORT] <= WIN_SHORT_RST;
            win_len_reg[WIN_MID]   <= WIN_MID_RST;
            win_len_reg[WIN_LONG]  <= WIN_LONG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WIN_SHORT: win_len_reg[WIN_SHORT] <= cfg_wdata;
                CFG_WIN_MID:   win_len_reg[WIN_MID]   <= cfg_wdata;
                CFG_WIN_LONG:  win_len_reg[WIN_LONG]  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    twrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    twrm_core #(
        .TIME_BITS (TIME_BITS),
        .SUM_BITS  (SUM_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .win_len (win_len_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/twrm_queue.sv =====
`timescale 1ns / 1ps
// twrm_queue: front end of the meter; takes event words off the input
// channel into a short queue that the back end drains. Uses twrm_pkg.

module twrm_queue
    import twrm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  twrm_in_t s_data,
    output logic     q_valid,
    output twrm_in_t q_data,
    input  logic     q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twrm_in_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign s_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_pop && q_valid;

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

// ===== rtl/twrm_div.sv =====
`timescale 1ns / 1ps
// twrm_div: restoring divider, one quotient bit per cycle, with the
// quotient saturated to the rate width. Uses twrm_pkg.

module twrm_div
    import twrm_pkg::*;
#(
    parameter int DVD_W = SUM_BITS_DEF + SCALE_BITS,
    parameter int DEN_W = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DVD_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output twrm_div_stat_t       stat,
    output logic [RATE_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [RATE_BITS-1:0] quo_reg;
    logic                 over_reg;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 take;

    // one restoring step
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign take    = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = over_reg ? RATE_MAX : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath; a quotient bit at or above the rate width only flags overflow
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            dvd_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg  <= {quo_reg[RATE_BITS-2:0], take};
            over_reg <= over_reg || (take && (cnt_reg > CNT_W'(RATE_BITS)));
        end
    end

endmodule

// ===== rtl/twrm_core.sv =====
`timescale 1ns / 1ps
// twrm_core: back end of the meter; holds the three window sums and start
// times, runs each window with nonzero elapsed time through the shared divider, and registers the
// result word. Uses twrm_pkg and twrm_div.

module twrm_core
    import twrm_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int SUM_BITS  = SUM_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  twrm_in_t  q_data,
    output logic      q_pop,
    input  twrm_len_t win_len,
    output logic      m_valid,
    input  logic      m_ready,
    output twrm_out_t m_data
);

    localparam int PW = SUM_BITS + SCALE_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_LAUNCH = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_ADV    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] win_reg, win_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_load;
    logic       div_start;

    // window state
    logic [SUM_BITS-1:0]  sum_reg   [NUM_WIN];
    logic [TIME_BITS-1:0] start_reg [NUM_WIN];

    // current item and per-window work registers
    logic [BYTE_BITS-1:0]             bytes_reg;
    logic [NOW_BITS-1:0]              now_reg;
    logic [SUM_BITS-1:0]              s_work_reg;
    logic [TIME_BITS-1:0]             e_work_reg;
    logic                             e_zero_reg;
    logic [PW-1:0]                    prod_reg;
    logic [NUM_WIN-1:0][RATE_BITS-1:0] rate_work_reg;
    logic [NUM_WIN-1:0]               zbits_reg;
    twrm_out_t                        out_reg;

    logic [SUM_BITS-1:0]  bytes_ext;
    logic [SUM_BITS:0]    sum_add;
    logic [SUM_BITS-1:0]  sum_sat;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 restart;

    twrm_div_stat_t       div_stat;
    logic [RATE_BITS-1:0] div_quo;

    // saturating sum and elapsed time of the current window
    assign bytes_ext = SUM_BITS'({32'd0, bytes_reg});
    assign sum_add   = {1'b0, sum_reg[win_reg]} + {1'b0, bytes_ext};
    assign sum_sat   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
    assign now_t     = TIME_BITS'({{(64 - NOW_BITS){1'b0}}, now_reg});
    assign elapsed   = now_t - start_reg[win_reg];
    assign restart   = elapsed > TIME_BITS'(win_len[win_reg]);

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = (state_reg == ST_LAUNCH);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    twrm_div #(
        .DVD_W (PW),
        .DEN_W (TIME_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (e_work_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // sequencer: three windows in turn, then hand off the result word
    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    win_next   = WIN_SHORT;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = e_zero_reg ? ST_ADV : ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                if (win_reg == WIN_LONG) begin
                    state_next = ST_OUT;
                end else begin
                    win_next   = win_reg + 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= WIN_SHORT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // window sums and start times; a window past its length restarts now
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                sum_reg[i]   <= '0;
                start_reg[i] <= '0;
            end
        end else if (state_reg == ST_PREP) begin
            sum_reg[win_reg] <= restart ? '0 : sum_sat;
            if (restart) begin
                start_reg[win_reg] <= now_t;
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    bytes_reg <= q_data.byte_count;
                    now_reg   <= q_data.now_ms;
                end
            end
            ST_PREP: begin
                s_work_reg <= sum_sat;
                e_work_reg <= elapsed;
                e_zero_reg <= (elapsed == '0);
            end
            ST_SCALE: begin
                prod_reg <= PW'(s_work_reg) * PW'(MS_PER_S);
                if (e_zero_reg) begin
                    rate_work_reg[win_reg] <= RATE_MAX;
                    zbits_reg[win_reg]     <= 1'b1;
                end else begin
                    zbits_reg[win_reg]     <= 1'b0;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    rate_work_reg[win_reg] <= div_quo;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    out_reg.rate_short   <= rate_work_reg[WIN_SHORT];
                    out_reg.rate_mid     <= rate_work_reg[WIN_MID];
                    out_reg.rate_long    <= rate_work_reg[WIN_LONG];
                    out_reg.zero_elapsed <= zbits_reg;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    // the divider is only launched when idle
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    // a finished division only arrives while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside wait state");

    // window select never passes the last window
    a_win_range: assert property (@(posedge aclk) disable iff (!aresetn)
        win_reg != 2'd3)
        else $error("window select out of range");

    // a result word is never overwritten before it is taken
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten");

    // a new item is taken only once the previous one left the sequencer
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == ST_PREP) && (win_reg == WIN_SHORT))
        else $error("item taken out of turn");
`endif

endmodule
